// File: rtl/core/multi_slot_deadline_monitor_core_defines.svh
// ============================================================================
// Deadline monitor assertion macros
// Shared property forms for the checkers of the deadline monitor core.
// ============================================================================
`ifndef MULTI_SLOT_DEADLINE_MONITOR_CORE_DEFINES_SVH
`define MULTI_SLOT_DEADLINE_MONITOR_CORE_DEFINES_SVH

// Antecedent and consequent hold in the same cycle.
`define MSDM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MSDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/msdm_pkg.sv
// ============================================================================
// Deadline monitor package
// Operation codes, result kinds and control types of the deadline monitor.
// ============================================================================
package msdm_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_IN_W = 4;
    localparam int TMO_W    = 24;
    localparam int OUT_TIME_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_WATCH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNWATCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

    localparam logic KIND_EXPIRY  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Control from the scan sequencer to the deadline tracker.
    typedef struct packed {
        logic clear;
        logic check;
    } t_trk_ctl;

endpackage

// File: rtl/core/msdm_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module msdm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/msdm_track.sv
// ============================================================================
// Deadline tracker
// Decides expiry of the deadline read from the table and keeps the earliest
// deadline still pending during a tick scan.
// ============================================================================
module msdm_track #(
    parameter int TIME_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msdm_pkg::t_trk_ctl    i_ctl,
    input  logic [TIME_BITS-1:0]  i_deadline,
    input  logic [TIME_BITS-1:0]  i_time,
    output logic                  o_expire,
    output logic                  o_pending,
    output logic [TIME_BITS-1:0]  o_earliest
);

    logic                 r_pending;
    logic                 n_pending;
    logic [TIME_BITS-1:0] r_earliest;
    logic [TIME_BITS-1:0] n_earliest;
    logic                 expire;

    assign expire = (i_deadline <= i_time);

    always_comb begin
        n_pending  = r_pending;
        n_earliest = r_earliest;
        if (i_ctl.clear) begin
            n_pending  = 1'b0;
            n_earliest = '0;
        end else if (i_ctl.check && !expire) begin
            if (!r_pending || (i_deadline < r_earliest)) begin
                n_pending  = 1'b1;
                n_earliest = i_deadline;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
        r_earliest <= n_earliest;
    end

    assign o_expire   = expire;
    assign o_pending  = r_pending;
    assign o_earliest = r_earliest;

endmodule

// File: rtl/core/multi_slot_deadline_monitor_core.sv
// ============================================================================
// Multi-slot deadline monitor
// Table of watched slots with absolute deadlines against a millisecond clock.
// ============================================================================
// A watch or unwatch request leaves busy low, and the next request may
// follow at once. A tick request raises busy through the scan, drain and summary
// states, and the next request is taken once the block is idle again; scan
// length is set by the single read port of the deadline memory, which scans
// one slot per cycle. Expiry results come out in ascending slot order, one
// per cycle with o_strobe high, followed by one summary result with o_last
// high. Results are shown for exactly one cycle and cannot be held off.
module multi_slot_deadline_monitor_core #(
    parameter int SLOT_COUNT = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [msdm_pkg::FUNC_W-1:0]       i_func,
    input  logic [msdm_pkg::SLOT_IN_W-1:0]    i_slot,
    input  logic [msdm_pkg::TMO_W-1:0]        i_timeout_ms,
    output logic                              o_strobe,
    output logic                              o_kind,
    output logic [msdm_pkg::SLOT_IN_W-1:0]    o_expired_slot,
    output logic                              o_has_pending,
    output logic [msdm_pkg::OUT_TIME_W-1:0]   o_earliest_deadline,
    output logic                              o_last
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_SUM   = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      n_idx;
    logic                   r_ev_vld;
    logic                   n_ev_vld;
    logic [SLOT_W-1:0]      r_ev_idx;
    logic [SLOT_W-1:0]      n_ev_idx;
    logic [TIME_BITS-1:0]   r_time;
    logic [TIME_BITS-1:0]   n_time;
    logic [SLOT_COUNT-1:0]  r_active;
    logic [SLOT_COUNT-1:0]  n_active;

    logic                             r_strobe;
    logic                             n_strobe;
    logic                             r_kind;
    logic                             n_kind;
    logic [msdm_pkg::SLOT_IN_W-1:0]   r_exp_slot;
    logic [msdm_pkg::SLOT_IN_W-1:0]   n_exp_slot;
    logic                             r_has_pend;
    logic                             n_has_pend;
    logic [msdm_pkg::OUT_TIME_W-1:0]  r_earliest;
    logic [msdm_pkg::OUT_TIME_W-1:0]  n_earliest;
    logic                             r_last;
    logic                             n_last;

    logic                   accept;
    logic                   slot_ok;
    logic [SLOT_W-1:0]      in_addr;
    logic [TIME_BITS:0]     dl_sum;
    logic [TIME_BITS-1:0]   dl_sat;
    logic                   we;
    logic [TIME_BITS-1:0]   rd_deadline;
    logic                   ev_active;
    logic                   expire;
    logic                   trk_pending;
    logic [TIME_BITS-1:0]   trk_earliest;
    msdm_pkg::t_trk_ctl     trk_ctl;

    assign accept  = start && (r_state == ST_IDLE);
    assign slot_ok = (32'(i_slot) < SLOT_COUNT);
    assign in_addr = SLOT_W'(i_slot);

    // Deadline of a watch saturates at the top of the time range.
    assign dl_sum = {1'b0, r_time} + (TIME_BITS + 1)'(i_timeout_ms);
    assign dl_sat = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];
    assign we     = accept && (i_func == msdm_pkg::FUNC_WATCH) && slot_ok;

    msdm_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (in_addr),
        .i_wdata (dl_sat),
        .i_raddr (r_idx),
        .o_rdata (rd_deadline)
    );

    assign ev_active     = r_ev_vld && r_active[r_ev_idx];
    assign trk_ctl.clear = accept && (i_func == msdm_pkg::FUNC_TICK);
    assign trk_ctl.check = ev_active;

    msdm_track #(
        .TIME_BITS (TIME_BITS)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (trk_ctl),
        .i_deadline (rd_deadline),
        .i_time     (r_time),
        .o_expire   (expire),
        .o_pending  (trk_pending),
        .o_earliest (trk_earliest)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_ev_vld   = 1'b0;
        n_ev_idx   = r_idx;
        n_time     = r_time;
        n_active   = r_active;
        n_strobe   = 1'b0;
        n_kind     = msdm_pkg::KIND_EXPIRY;
        n_exp_slot = '0;
        n_has_pend = 1'b0;
        n_earliest = '0;
        n_last     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        msdm_pkg::FUNC_WATCH: begin
                            if (slot_ok) begin
                                n_active[in_addr] = 1'b1;
                            end
                        end
                        msdm_pkg::FUNC_UNWATCH: begin
                            if (slot_ok) begin
                                n_active[in_addr] = 1'b0;
                            end
                        end
                        msdm_pkg::FUNC_TICK: begin
                            if (r_time != '1) begin
                                n_time = r_time + TIME_BITS'(1);
                            end
                            n_idx   = '0;
                            n_state = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Read of r_idx is in flight; its data is judged next cycle.
                n_ev_vld = 1'b1;
                n_ev_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_strobe   = 1'b1;
                n_kind     = msdm_pkg::KIND_SUMMARY;
                n_has_pend = trk_pending;
                n_earliest = msdm_pkg::OUT_TIME_W'(trk_earliest);
                n_last     = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (ev_active && expire) begin
            n_active[r_ev_idx] = 1'b0;
            n_strobe           = 1'b1;
            n_kind             = msdm_pkg::KIND_EXPIRY;
            n_exp_slot         = msdm_pkg::SLOT_IN_W'(r_ev_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ev_vld <= 1'b0;
            r_time   <= '0;
            r_active <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            r_time   <= n_time;
            r_active <= n_active;
            r_strobe <= n_strobe;
        end
        r_idx      <= n_idx;
        r_ev_idx   <= n_ev_idx;
        r_kind     <= n_kind;
        r_exp_slot <= n_exp_slot;
        r_has_pend <= n_has_pend;
        r_earliest <= n_earliest;
        r_last     <= n_last;
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_strobe            = r_strobe;
    assign o_kind              = r_kind;
    assign o_expired_slot      = r_exp_slot;
    assign o_has_pending       = r_has_pend;
    assign o_earliest_deadline = r_earliest;
    assign o_last              = r_last;

endmodule

// File: rtl/core/msdm_chk.sv
// ============================================================================
// Deadline monitor checker
// Port-level properties of the deadline monitor core, bound to the top level.
// ============================================================================
`include "multi_slot_deadline_monitor_core_defines.svh"

module msdm_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [msdm_pkg::FUNC_W-1:0]       i_func,
    input  logic                              o_strobe,
    input  logic                              o_kind,
    input  logic                              o_has_pending,
    input  logic [msdm_pkg::OUT_TIME_W-1:0]   o_earliest_deadline,
    input  logic                              o_last
);

    logic tick_req;
    logic sum_out;
    logic exp_out;

    assign tick_req = start && !busy && (i_func == msdm_pkg::FUNC_TICK);
    assign sum_out  = o_strobe && (o_kind == msdm_pkg::KIND_SUMMARY);
    assign exp_out  = o_strobe && (o_kind == msdm_pkg::KIND_EXPIRY);

    // A tick request starts a scan.
    `MSDM_ASSERT_NEXT(a_tick_busy, tick_req, busy, "tick request did not start a scan")

    // Only the summary closes a tick.
    `MSDM_ASSERT_SAME(a_last_kind, o_strobe, o_last == o_kind, "last flag disagrees with kind")

    // Expiry notices come out while the scan still holds the block.
    `MSDM_ASSERT_SAME(a_exp_busy, exp_out, busy, "expiry notice outside a scan")

    // The summary follows the end of the scan.
    `MSDM_ASSERT_SAME(a_sum_idle, sum_out, !busy, "summary while still busy")

    // Nothing pending means an empty earliest deadline.
    `MSDM_ASSERT_SAME(a_sum_empty, sum_out && !o_has_pending, o_earliest_deadline == '0,
        "earliest deadline set with nothing pending")

endmodule

bind multi_slot_deadline_monitor_core msdm_chk u_msdm_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_func              (i_func),
    .o_strobe            (o_strobe),
    .o_kind              (o_kind),
    .o_has_pending       (o_has_pending),
    .o_earliest_deadline (o_earliest_deadline),
    .o_last              (o_last)
);
